// ===== rtl/s5hs_pkg.sv =====
// Package for the SOCKS5 server handshake parser: phase, result kind and
// reply-sequence types, protocol constants, and reply-byte helpers.
// No dependencies.
package s5hs_pkg;

    localparam int unsigned IDX_W     = 4;   // result index within one descriptor
    localparam int unsigned REPLY_LEN = 10;  // bytes in a request reply

    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
    localparam logic [7:0] METHOD_NONE    = 8'hFF;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] REP_OK         = 8'h00;
    localparam logic [7:0] REP_CMD_UNSUP  = 8'h07;
    localparam logic [7:0] REP_ATYP_UNSUP = 8'h08;
    localparam logic [7:0] REP_RSV        = 8'h00;

    typedef enum logic [4:0] {
        PH_NEGOTIATE = 5'b00001,
        PH_REQUEST   = 5'b00010,
        PH_RELAY     = 5'b00100,
        PH_CLOSING   = 5'b01000,
        PH_CLOSED    = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        K_REPLY       = 3'd0,
        K_OPEN4       = 3'd1,
        K_DOMAIN      = 3'd2,
        K_OPENDOM     = 3'd3,
        K_RELAY       = 3'd4,
        K_CLOSE_LATER = 3'd5,
        K_CLOSE_NOW   = 3'd6
    } t_kind;

    // Shape of the result burst caused by one client byte
    typedef enum logic [2:0] {
        SEQ_SINGLE   = 3'd0,  // one result: kind + data
        SEQ_NEG_OK   = 3'd1,  // 05 00
        SEQ_NEG_FAIL = 3'd2,  // 05 FF, close later
        SEQ_REQ_FAIL = 3'd3,  // 10-byte reply with error code, close later
        SEQ_OPEN     = 3'd4   // open event, 10-byte success reply
    } t_seq;

    typedef struct packed {
        t_seq        seq;
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  code;
    } t_desc;

    function automatic logic [IDX_W-1:0] seq_len(input t_seq s);
        logic [IDX_W-1:0] len;
        unique case (s)
            SEQ_SINGLE:   len = IDX_W'(1);
            SEQ_NEG_OK:   len = IDX_W'(2);
            SEQ_NEG_FAIL: len = IDX_W'(3);
            SEQ_REQ_FAIL: len = IDX_W'(REPLY_LEN + 1);
            SEQ_OPEN:     len = IDX_W'(REPLY_LEN + 1);
            default:      len = IDX_W'(1);
        endcase
        return len;
    endfunction

    // Byte at position pos of the reply: VER REP RSV ATYP(1) 0.0.0.0 PORT
    function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] pos,
                                              input logic [7:0] code,
                                              input logic [15:0] port);
        logic [7:0] b;
        unique case (pos)
            IDX_W'(0): b = SOCKS_VER;
            IDX_W'(1): b = code;
            IDX_W'(2): b = REP_RSV;
            IDX_W'(3): b = ATYP_IPV4;
            IDX_W'(8): b = port[15:8];
            IDX_W'(9): b = port[7:0];
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/socks5_handshake_parser.sv =====
// Top level of the SOCKS5 server handshake parser (no auth, CONNECT only).
// Depends on s5hs_pkg for types, constants and reply-byte helpers.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  input    | in        | i_valid / o_stall  | i_action, i_data_byte
//  result   | out       | o_valid / i_stall  | o_kind, o_out_byte, o_dest_address,
//           |           |                    | o_dest_port, o_last
//
//  One client byte can be taken every cycle while o_stall is low. The parser state
//  updates in the accept cycle and pushes one burst descriptor into a two-slot
//  queue; the output side plays a descriptor out at one result per cycle while
//  i_stall is low (1 to 11 results per descriptor).
//  o_stall rises only when both queue slots are occupied (registered, no path
//  from i_stall). Reset is synchronous and active low.
//  Items that cause no result (new connection, bytes after close) push nothing.
module socks5_handshake_parser
    import s5hs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_dest_port,
    output logic        o_last
);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase      r_phase,        n_phase;
    logic [8:0]  r_byte_count,   n_byte_count;
    logic [7:0]  r_version_seen, n_version_seen;
    logic [7:0]  r_method_count, n_method_count;
    logic        r_no_auth,      n_no_auth;
    logic [7:0]  r_address_type, n_address_type;   // holds command until ATYP arrives
    logic [7:0]  r_domain_len,   n_domain_len;
    logic [31:0] r_addr_shift,   n_addr_shift;
    logic [15:0] r_port_shift,   n_port_shift;

    // Descriptor queue (two slots)
    t_desc            r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic [IDX_W-1:0] r_idx;

    logic  w_accept;
    logic  w_push;
    logic  w_pop;
    logic  w_fire;
    t_desc n_desc;
    t_desc w_head;
    logic [IDX_W-1:0] w_len;
    logic  w_done;

    assign o_stall  = (r_cnt == 2'd2);
    assign w_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Next-state logic for one accepted transaction
    // ------------------------------------------------------------------
    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_version_seen = r_version_seen;
        n_method_count = r_method_count;
        n_no_auth      = r_no_auth;
        n_address_type = r_address_type;
        n_domain_len   = r_domain_len;
        n_addr_shift   = r_addr_shift;
        n_port_shift   = r_port_shift;
        w_push         = 1'b0;
        w_done         = 1'b0;
        n_desc         = '{seq: SEQ_SINGLE, kind: K_REPLY, data: 8'h00,
                           addr: 32'h0, port: 16'h0, code: 8'h00};

        if (w_accept) begin
            if (!i_action) begin
                // new connection: back to the start, nothing emitted
                n_phase        = PH_NEGOTIATE;
                n_byte_count   = 9'd0;
                n_version_seen = 8'h00;
                n_method_count = 8'h00;
                n_no_auth      = 1'b0;
                n_address_type = 8'h00;
                n_domain_len   = 8'h00;
                n_addr_shift   = 32'h0;
                n_port_shift   = 16'h0;
            end else begin
                unique case (r_phase)
                    PH_NEGOTIATE: begin
                        n_byte_count = r_byte_count + 9'd1;
                        if (r_byte_count == 9'd0) begin
                            n_version_seen = i_data_byte;
                        end else if (r_byte_count == 9'd1) begin
                            n_method_count = i_data_byte;
                            w_done         = (i_data_byte == 8'h00);
                        end else begin
                            if (i_data_byte == METHOD_NO_AUTH) begin
                                n_no_auth = 1'b1;
                            end
                            w_done = (r_byte_count == ({1'b0, r_method_count} + 9'd1));
                        end
                        if (w_done) begin
                            w_push = 1'b1;
                            if (r_version_seen != SOCKS_VER) begin
                                n_desc.kind = K_CLOSE_NOW;
                                n_phase     = PH_CLOSED;
                            end else if (n_no_auth) begin
                                n_desc.seq   = SEQ_NEG_OK;
                                n_phase      = PH_REQUEST;
                                n_byte_count = 9'd0;
                            end else begin
                                n_desc.seq = SEQ_NEG_FAIL;
                                n_phase    = PH_CLOSING;
                            end
                        end
                    end

                    PH_REQUEST: begin
                        n_byte_count = r_byte_count + 9'd1;
                        if (r_byte_count == 9'd0) begin
                            n_version_seen = i_data_byte;
                        end else if (r_byte_count == 9'd1) begin
                            n_address_type = i_data_byte;
                        end else if (r_byte_count == 9'd2) begin
                            // reserved byte, ignored
                        end else if (r_byte_count == 9'd3) begin
                            if (r_version_seen != SOCKS_VER) begin
                                w_push      = 1'b1;
                                n_desc.kind = K_CLOSE_NOW;
                                n_phase     = PH_CLOSED;
                            end else if (r_address_type != CMD_CONNECT) begin
                                w_push      = 1'b1;
                                n_desc.seq  = SEQ_REQ_FAIL;
                                n_desc.code = REP_CMD_UNSUP;
                                n_phase     = PH_CLOSING;
                            end else if (i_data_byte == ATYP_IPV4 ||
                                         i_data_byte == ATYP_DOMAIN) begin
                                n_address_type = i_data_byte;
                            end else begin
                                w_push      = 1'b1;
                                n_desc.seq  = SEQ_REQ_FAIL;
                                n_desc.code = REP_ATYP_UNSUP;
                                n_phase     = PH_CLOSING;
                            end
                        end else if (r_address_type == ATYP_IPV4) begin
                            if (r_byte_count <= 9'd7) begin
                                n_addr_shift = {r_addr_shift[23:0], i_data_byte};
                            end else begin
                                n_port_shift = {r_port_shift[7:0], i_data_byte};
                                if (r_byte_count == 9'd9) begin
                                    w_push      = 1'b1;
                                    n_desc.seq  = SEQ_OPEN;
                                    n_desc.kind = K_OPEN4;
                                    n_desc.addr = r_addr_shift;
                                    n_desc.port = n_port_shift;
                                    n_desc.code = REP_OK;
                                    n_phase     = PH_RELAY;
                                end
                            end
                        end else begin
                            // domain name: length, name bytes, two port bytes
                            if (r_byte_count == 9'd4) begin
                                n_domain_len = i_data_byte;
                            end else if (r_byte_count <= ({1'b0, r_domain_len} + 9'd4)) begin
                                w_push      = 1'b1;
                                n_desc.kind = K_DOMAIN;
                                n_desc.data = i_data_byte;
                            end else begin
                                n_port_shift = {r_port_shift[7:0], i_data_byte};
                                if (r_byte_count == ({1'b0, r_domain_len} + 9'd6)) begin
                                    w_push      = 1'b1;
                                    n_desc.seq  = SEQ_OPEN;
                                    n_desc.kind = K_OPENDOM;
                                    n_desc.port = n_port_shift;
                                    n_desc.code = REP_OK;
                                    n_phase     = PH_RELAY;
                                end
                            end
                        end
                    end

                    PH_RELAY: begin
                        w_push      = 1'b1;
                        n_desc.kind = K_RELAY;
                        n_desc.data = i_data_byte;
                    end

                    default: begin
                        // closing / closed: bytes are dropped
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result playout from the queue head
    // ------------------------------------------------------------------
    assign w_head  = r_q[r_rd_ptr];
    assign w_len   = seq_len(w_head.seq);
    assign o_valid = (r_cnt != 2'd0);
    assign o_last  = (r_idx == (w_len - IDX_W'(1)));
    assign w_fire  = o_valid && !i_stall;
    assign w_pop   = w_fire && o_last;

    always_comb begin
        o_kind         = K_REPLY;
        o_out_byte     = 8'h00;
        o_dest_address = 32'h0;
        o_dest_port    = 16'h0;
        unique case (w_head.seq)
            SEQ_SINGLE: begin
                o_kind     = w_head.kind;
                o_out_byte = w_head.data;
            end
            SEQ_NEG_OK: begin
                o_out_byte = (r_idx == IDX_W'(0)) ? SOCKS_VER : METHOD_NO_AUTH;
            end
            SEQ_NEG_FAIL: begin
                if (r_idx == IDX_W'(0)) begin
                    o_out_byte = SOCKS_VER;
                end else if (r_idx == IDX_W'(1)) begin
                    o_out_byte = METHOD_NONE;
                end else begin
                    o_kind = K_CLOSE_LATER;
                end
            end
            SEQ_REQ_FAIL: begin
                if (r_idx == IDX_W'(REPLY_LEN)) begin
                    o_kind = K_CLOSE_LATER;
                end else begin
                    o_out_byte = reply_byte(r_idx, w_head.code, 16'h0);
                end
            end
            SEQ_OPEN: begin
                if (r_idx == IDX_W'(0)) begin
                    o_kind         = w_head.kind;
                    o_dest_address = w_head.addr;
                    o_dest_port    = w_head.port;
                end else begin
                    o_out_byte = reply_byte(r_idx - IDX_W'(1), w_head.code, w_head.port);
                end
            end
            default: begin
                o_kind = K_REPLY;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_NEGOTIATE;
            r_byte_count   <= 9'd0;
            r_version_seen <= 8'h00;
            r_method_count <= 8'h00;
            r_no_auth      <= 1'b0;
            r_address_type <= 8'h00;
            r_domain_len   <= 8'h00;
            r_addr_shift   <= 32'h0;
            r_port_shift   <= 16'h0;
            r_wr_ptr       <= 1'b0;
            r_rd_ptr       <= 1'b0;
            r_cnt          <= 2'd0;
            r_idx          <= '0;
        end else begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_version_seen <= n_version_seen;
            r_method_count <= n_method_count;
            r_no_auth      <= n_no_auth;
            r_address_type <= n_address_type;
            r_domain_len   <= n_domain_len;
            r_addr_shift   <= n_addr_shift;
            r_port_shift   <= n_port_shift;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_idx    <= '0;
            end else if (w_fire) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= n_desc;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("descriptor queue overflow");

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < w_len))
        else $error("result index beyond burst length");

    a_burst_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (r_idx == '0))
        else $error("burst did not start at first result");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1 && w_pop && !w_push) |=> !o_valid)
        else $error("valid held after last descriptor drained");

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action && (r_phase == PH_CLOSING || r_phase == PH_CLOSED))
            |-> !w_push)
        else $error("result produced after close");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for socks5_handshake_parser: client byte streams in, every
// result burst predicted by a behavioral model of the handshake and checked in order.
// Depends on s5hs_pkg and the parser RTL.
module tb;
    import s5hs_pkg::*;

    localparam int TOTAL_ITEMS  = 310;     // least number of client transactions in all, directed part included
    localparam int TAIL_ITEMS   = 30;      // last stretch runs with no idling at all
    localparam int STALL_LIMIT  = 2000;    // cycles with no transaction on either side
    localparam int MAX_CYCLES   = 200000;  // hard stop for a run that never settles
    localparam int DRAIN_CYCLES = 30;      // settle time after the last result
    localparam int MAX_PRINTS   = 60;

    // Session shapes for the random part. The well-formed ones dominate.
    typedef enum int {
        SESS_IPV4,
        SESS_DOMAIN,
        SESS_NEG_BADVER,
        SESS_NO_METHOD,
        SESS_REQ_BADVER,
        SESS_BAD_CMD,
        SESS_BAD_ATYP,
        SESS_TRUNC,
        SESS_NOISE
    } t_session_kind;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } t_client_item;

    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [15:0] port;
        logic        last;
    } t_parser_result;

    // DUT ports; every input starts at a known value
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_action    = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [31:0] o_dest_address;
    logic [15:0] o_dest_port;
    logic        o_last;

    socks5_handshake_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_dest_address (o_dest_address),
        .o_dest_port    (o_dest_port),
        .o_last         (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus store and bookkeeping
    // ------------------------------------------------------------------
    t_client_item   client_bytes[$];   // pending transactions for the driver
    t_client_item   session_bytes[$];  // one session under construction
    t_parser_result expected_results[$];

    int  n_errors     = 0;
    int  n_accepted   = 0;
    int  n_checked    = 0;
    int  n_opens      = 0;
    int  n_domain     = 0;
    int  n_relayed    = 0;
    int  n_closes     = 0;
    int  n_sessions   = 0;
    int  n_directed   = 0;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    int  cyc_count    = 0;
    bit  bursty       = 1'b1;
    bit  timed_out    = 1'b0;
    logic in_taken    = 1'b0;

    // ------------------------------------------------------------------
    // Handshake model: own copy of the parser state
    // ------------------------------------------------------------------
    t_phase      ph        = PH_NEGOTIATE;
    logic [8:0]  idx_cnt   = '0;   // byte position within the current message
    logic [7:0]  ver_seen  = '0;
    logic [7:0]  n_methods = '0;
    logic        no_auth   = 1'b0;
    logic [7:0]  held_type = '0;   // command byte until ATYP arrives, then ATYP
    logic [7:0]  dom_len   = '0;
    logic [31:0] addr_acc  = '0;
    logic [15:0] port_acc  = '0;

    task automatic clear_session();
        ph        = PH_NEGOTIATE;
        idx_cnt   = '0;
        ver_seen  = '0;
        n_methods = '0;
        no_auth   = 1'b0;
        held_type = '0;
        dom_len   = '0;
        addr_acc  = '0;
        port_acc  = '0;
    endtask

    task automatic add_result(input t_kind k, input logic [7:0] d,
                              input logic [31:0] a, input logic [15:0] p);
        t_parser_result r;
        r.kind = k;
        r.data = d;
        r.addr = a;
        r.port = p;
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    // VER REP RSV ATYP 0.0.0.0 PORT
    task automatic add_reply(input logic [7:0] code, input logic [15:0] p);
        add_result(K_REPLY, SOCKS_VER, '0, '0);
        add_result(K_REPLY, code, '0, '0);
        add_result(K_REPLY, REP_RSV, '0, '0);
        add_result(K_REPLY, ATYP_IPV4, '0, '0);
        repeat (4) add_result(K_REPLY, 8'h00, '0, '0);
        add_result(K_REPLY, p[15:8], '0, '0);
        add_result(K_REPLY, p[7:0], '0, '0);
    endtask

    task automatic refuse_request(input logic [7:0] code);
        add_reply(code, '0);
        add_result(K_CLOSE_LATER, '0, '0, '0);
        ph = PH_CLOSING;
    endtask

    task automatic negotiate_byte(input logic [7:0] b);
        bit done;
        done = 1'b0;
        if (idx_cnt == 9'd0) begin
            ver_seen = b;
        end else if (idx_cnt == 9'd1) begin
            n_methods = b;
            done = (b == 8'd0);
        end else begin
            if (b == METHOD_NO_AUTH) no_auth = 1'b1;
            done = (idx_cnt == {1'b0, n_methods} + 9'd1);
        end
        idx_cnt = idx_cnt + 9'd1;
        if (!done) return;
        // version is judged only once the whole method list is in
        if (ver_seen != SOCKS_VER) begin
            add_result(K_CLOSE_NOW, '0, '0, '0);
            ph = PH_CLOSED;
        end else if (no_auth) begin
            add_result(K_REPLY, SOCKS_VER, '0, '0);
            add_result(K_REPLY, METHOD_NO_AUTH, '0, '0);
            ph = PH_REQUEST;
            idx_cnt = '0;
        end else begin
            add_result(K_REPLY, SOCKS_VER, '0, '0);
            add_result(K_REPLY, METHOD_NONE, '0, '0);
            add_result(K_CLOSE_LATER, '0, '0, '0);
            ph = PH_CLOSING;
        end
    endtask

    task automatic request_byte(input logic [7:0] b);
        logic [8:0] idx;
        idx = idx_cnt;
        idx_cnt = idx_cnt + 9'd1;
        // position 2 is the reserved byte and is dropped
        if (idx == 9'd0) begin
            ver_seen = b;
        end else if (idx == 9'd1) begin
            held_type = b;
        end else if (idx == 9'd3) begin
            if (ver_seen != SOCKS_VER) begin
                add_result(K_CLOSE_NOW, '0, '0, '0);
                ph = PH_CLOSED;
            end else if (held_type != CMD_CONNECT) begin
                refuse_request(REP_CMD_UNSUP);
            end else if (b == ATYP_IPV4 || b == ATYP_DOMAIN) begin
                held_type = b;
            end else begin
                refuse_request(REP_ATYP_UNSUP);
            end
        end else if (idx > 9'd3) begin
            if (held_type == ATYP_IPV4) begin
                if (idx <= 9'd7) begin
                    addr_acc = {addr_acc[23:0], b};
                end else begin
                    port_acc = {port_acc[7:0], b};
                    if (idx == 9'd9) begin
                        add_result(K_OPEN4, '0, addr_acc, port_acc);
                        add_reply(REP_OK, port_acc);
                        ph = PH_RELAY;
                    end
                end
            end else begin
                if (idx == 9'd4) begin
                    dom_len = b;
                end else if (idx <= {1'b0, dom_len} + 9'd4) begin
                    add_result(K_DOMAIN, b, '0, '0);
                end else begin
                    port_acc = {port_acc[7:0], b};
                    if (idx == {1'b0, dom_len} + 9'd6) begin
                        add_result(K_OPENDOM, '0, '0, port_acc);
                        add_reply(REP_OK, port_acc);
                        ph = PH_RELAY;
                    end
                end
            end
        end
    endtask

    // One accepted client transaction -> its burst of expected results
    task automatic predict_transaction(input logic act, input logic [7:0] b);
        int first;
        first = expected_results.size();
        if (!act) begin
            clear_session();
            return;
        end
        case (ph)
            PH_NEGOTIATE: negotiate_byte(b);
            PH_REQUEST:   request_byte(b);
            PH_RELAY:     add_result(K_RELAY, b, '0, '0);
            default:      ;   // closing or closed: byte is dropped
        endcase
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("MISMATCH @%0t result %0d %s: got %h, want %h",
                     $realtime, n_checked, what, got, want);
    endtask

    task automatic check_result();
        t_parser_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'(o_kind), '0);
            return;
        end
        want = expected_results.pop_front();
        n_checked++;
        case (want.kind)
            K_OPEN4, K_OPENDOM:         n_opens++;
            K_DOMAIN:                   n_domain++;
            K_RELAY:                    n_relayed++;
            K_CLOSE_LATER, K_CLOSE_NOW: n_closes++;
            default:                    ;
        endcase
        if (o_kind !== want.kind)           report_mismatch("kind", 32'(o_kind), 32'(want.kind));
        if (o_out_byte !== want.data)       report_mismatch("out_byte", 32'(o_out_byte),
                                                            32'(want.data));
        if (o_dest_address !== want.addr)   report_mismatch("dest_address", o_dest_address,
                                                            want.addr);
        if (o_dest_port !== want.port)      report_mismatch("dest_port", 32'(o_dest_port),
                                                            32'(want.port));
        if (o_last !== want.last)           report_mismatch("last", 32'(o_last), 32'(want.last));
    endtask

    // Monitor: samples both channels at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && (o_stall === 1'b0);
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) check_result();
            if (i_valid && o_stall === 1'b0) begin
                predict_transaction(i_action, i_data_byte);
                n_accepted++;
            end
            // watchdog: any transaction on either side restarts the count
            if ((o_valid === 1'b1 && !i_stall) || (i_valid && o_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_inputs
        t_client_item nxt;
        if (i_rst_n) begin
            cyc_count++;
            // idling comes and goes in windows; none in the tail
            if (client_bytes.size() < TAIL_ITEMS)
                bursty = 1'b0;
            else if (cyc_count % 64 == 0)
                bursty = ($urandom_range(0, 3) != 0);

            // sender: hold the payload until it is taken
            if (!i_valid || in_taken) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (client_bytes.size() > 0) begin
                    nxt = client_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_action <= nxt.act;
                    i_data_byte <= nxt.data;
                    if (bursty && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 13);
                end else begin
                    i_valid <= 1'b0;
                end
            end

            // receiver: stall in random bursts
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (bursty && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                stall_left <= $urandom_range(0, 12);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] v;
        do v = 8'($urandom); while (v == a || v == c);
        return v;
    endfunction

    task automatic put(input logic act, input logic [7:0] b);
        t_client_item it;
        it.act = act;
        it.data = b;
        session_bytes.push_back(it);
    endtask

    task automatic commit(input int keep);
        for (int i = 0; i < keep && i < session_bytes.size(); i++)
            client_bytes.push_back(session_bytes[i]);
        session_bytes.delete();
    endtask

    // trailing bytes after a close; the parser must drop them
    task automatic put_junk();
        repeat ($urandom_range(0, 3)) put(1'b1, 8'($urandom));
    endtask

    // VER NMETHODS METHODS; method 0 placed at a random spot when offered
    task automatic put_greeting(input logic [7:0] ver, input logic [7:0] nmeth,
                                input bit offer);
        int n;
        int at;
        n = nmeth;
        at = (n > 0) ? $urandom_range(0, n - 1) : -1;
        put(1'b1, ver);
        put(1'b1, nmeth);
        for (int i = 0; i < n; i++) begin
            if (offer && i == at)  put(1'b1, METHOD_NO_AUTH);
            else if (offer)        put(1'b1, 8'($urandom));
            else                   put(1'b1, byte_except(METHOD_NO_AUTH, METHOD_NO_AUTH));
        end
    endtask

    task automatic add_session(input t_session_kind k, input bit long_greet,
                               input bit long_name);
        logic [7:0] nmeth;
        logic [7:0] ver;
        logic [7:0] cmd;
        logic [7:0] atyp;
        logic [7:0] nlen;
        int cut;
        n_sessions++;
        if (k == SESS_NOISE) begin
            // loose bytes on top of whatever state the parser is in
            repeat ($urandom_range(3, 12))
                put($urandom_range(0, 7) != 0, 8'($urandom));
            commit(session_bytes.size());
            return;
        end
        put(1'b0, 8'($urandom));   // new connection
        nmeth = long_greet ? 8'd255 : 8'($urandom_range(1, 6));
        case (k)
            SESS_NEG_BADVER: begin
                put_greeting(byte_except(SOCKS_VER, SOCKS_VER),
                             8'($urandom_range(0, 6)), $urandom_range(0, 1));
                put_junk();
            end
            SESS_NO_METHOD: begin
                put_greeting(SOCKS_VER, ($urandom_range(0, 2) == 0) ? 8'd0 : nmeth, 1'b0);
                put_junk();
            end
            default: begin
                put_greeting(SOCKS_VER, nmeth, 1'b1);
                ver = (k == SESS_REQ_BADVER) ? byte_except(SOCKS_VER, SOCKS_VER) : SOCKS_VER;
                if (k == SESS_BAD_CMD)
                    cmd = byte_except(CMD_CONNECT, CMD_CONNECT);
                else if (k == SESS_REQ_BADVER)
                    cmd = 8'($urandom);
                else
                    cmd = CMD_CONNECT;
                case (k)
                    SESS_IPV4:     atyp = ATYP_IPV4;
                    SESS_DOMAIN:   atyp = ATYP_DOMAIN;
                    SESS_BAD_ATYP: atyp = byte_except(ATYP_IPV4, ATYP_DOMAIN);
                    SESS_TRUNC:    atyp = $urandom_range(0, 1) ? ATYP_IPV4 : ATYP_DOMAIN;
                    default:       atyp = 8'($urandom);
                endcase
                put(1'b1, ver);
                put(1'b1, cmd);
                put(1'b1, 8'($urandom));   // reserved
                put(1'b1, atyp);
                if (ver == SOCKS_VER && cmd == CMD_CONNECT &&
                    (atyp == ATYP_IPV4 || atyp == ATYP_DOMAIN)) begin
                    if (atyp == ATYP_IPV4) begin
                        repeat (4) put(1'b1, 8'($urandom));
                    end else begin
                        if (long_name)                      nlen = 8'd255;
                        else if ($urandom_range(0, 3) == 0) nlen = 8'd0;
                        else                                nlen = 8'($urandom_range(1, 10));
                        put(1'b1, nlen);
                        repeat (nlen) put(1'b1, 8'($urandom));
                    end
                    repeat (2) put(1'b1, 8'($urandom));   // port
                    repeat ($urandom_range(0, 8)) put(1'b1, 8'($urandom));   // relayed data
                end else begin
                    put_junk();
                end
            end
        endcase
        cut = session_bytes.size();
        if (k == SESS_TRUNC) cut = $urandom_range(2, session_bytes.size() - 1);
        commit(cut);
    endtask

    task automatic build_stimulus();
        int pick;
        int sess_idx;
        int long_at;
        // Straight out of reset, no new-connection transaction: full IPv4
        // CONNECT with all-ones address and port, then relay of both extremes.
        put(1'b1, SOCKS_VER); put(1'b1, 8'd1); put(1'b1, METHOD_NO_AUTH);
        put(1'b1, SOCKS_VER); put(1'b1, CMD_CONNECT); put(1'b1, 8'h00);
        put(1'b1, ATYP_IPV4);
        repeat (6) put(1'b1, 8'hFF);
        put(1'b1, 8'hFF); put(1'b1, 8'h00);
        // zero methods offered -> 05 FF, delayed close; later byte dropped
        put(1'b0, 8'hFF); put(1'b1, SOCKS_VER); put(1'b1, 8'd0); put(1'b1, 8'h5A);
        // wrong version in the greeting -> immediate close
        put(1'b0, 8'h00); put(1'b1, 8'h04); put(1'b1, 8'd1); put(1'b1, METHOD_NO_AUTH);
        commit(session_bytes.size());
        n_directed = client_bytes.size();

        // one session of every shape first, then a weighted mix
        for (int k = SESS_IPV4; k <= SESS_NOISE; k++)
            add_session(t_session_kind'(k), 1'b0, 1'b0);

        // one session may stretch a length field to 255 (method list or name)
        long_at = $urandom_range(0, 15);
        sess_idx = 0;
        while (client_bytes.size() < TOTAL_ITEMS) begin
            if (sess_idx == long_at) begin
                if ($urandom_range(0, 1)) add_session(SESS_IPV4, 1'b1, 1'b0);
                else                      add_session(SESS_DOMAIN, 1'b0, 1'b1);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick <= 6)       add_session(SESS_IPV4, 1'b0, 1'b0);
                else if (pick <= 12) add_session(SESS_DOMAIN, 1'b0, 1'b0);
                else                 add_session(t_session_kind'(pick - 11), 1'b0, 1'b0);
            end
            sess_idx++;
        end
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // run until every transaction is in and every result is out
        while ((client_bytes.size() > 0 || i_valid || expected_results.size() > 0)
               && !timed_out) begin
            @(negedge i_clk);
            if (idle_cycles >= STALL_LIMIT || cyc_count >= MAX_CYCLES) timed_out = 1'b1;
        end
        if (!timed_out) repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (timed_out) begin
            $display("watchdog: run stopped after %0d cycles, %0d results outstanding",
                     cyc_count, expected_results.size());
            $display("tb failed");
        end else begin
            $display("run: %0d client bytes (%0d directed) over %0d sessions",
                     n_accepted, n_directed, n_sessions);
            $display("run: %0d results checked, %0d opens, %0d domain, %0d relay, %0d closes",
                     n_checked, n_opens, n_domain, n_relayed, n_closes);
            if (n_errors == 0)
                $display("tb passed");
            else
                $display("tb failed");
        end
        $finish;
    end

endmodule
